// ----- src/bta_pkg.sv -----
// Shared types, constants and helpers for the binary-to-ASCII formatter.
package bta_pkg;

  localparam int DIGIT_W      = 4;
  localparam int NUM_DIGITS   = 20;
  localparam int BCD_W        = DIGIT_W * NUM_DIGITS;
  localparam int VALUE_W      = 64;
  localparam int BITS_PER_OP  = 2;
  localparam int DABBLE_STEPS = VALUE_W / BITS_PER_OP;
  localparam int CNT_W        = 5;
  localparam int CHAR_W       = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_X      = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;
  localparam logic [DIGIT_W-1:0] DEC_RADIX  = 4'd10;
  localparam logic [7:0]        HEX_PREFIX_LEN = 8'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TOO_SMALL = 1'b1;
  localparam logic KIND_HEX         = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DEC,
    OP_LOAD_HEX,
    OP_DABBLE,
    OP_SHIFT
  } unit_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_PRE0,
    ST_PREX,
    ST_EMIT,
    ST_ERR
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
    if (d < DEC_RADIX) begin
      return CHAR_ZERO + {3'b000, d};
    end else begin
      return CHAR_ALPHA + {3'b000, d - DEC_RADIX};
    end
  endfunction

endpackage

// ----- src/bta_if.sv -----
// Valid/ready channel interfaces for the formatter's input and result items.
interface bta_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        kind;
  logic [7:0]  capacity;

  modport source (output valid, value, kind, capacity, input ready);
  modport sink   (input valid, value, kind, capacity, output ready);
endinterface

interface bta_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       status;
  logic       last;

  modport source (output valid, character, status, last, input ready);
  modport sink   (input valid, character, status, last, output ready);
endinterface

// ----- src/binary_to_ascii_number_formatter.sv -----
// Top level: sequencer and result register of the binary-to-ASCII formatter.
//
//   channel  | dir | payload                          | accepted when
//   in_ch    | in  | value[63:0], kind, capacity[7:0] | valid && ready
//   out_ch   | out | character[6:0], status, last     | valid && ready
//
// Decimal, n digits: a load, 32 shift-add-3 passes (2 bits each), dropping the
// 20 - n leading zero digits, a size check, then n characters.
// Hex, n digits: a load, the scan of 20 - n leading zeros, the size check, the
// two prefix characters 0x, then n digits. A short buffer ends after the check
// with one error result. rst is synchronous and clears the sequencer and the
// result valid flag. A stalled result holds the sequencer in its output states;
// a new item is taken once the last result of the previous one sits in the output register.
module binary_to_ascii_number_formatter (
  input logic clk,
  input logic rst,
  bta_in_if.sink    in_ch,
  bta_out_if.source out_ch
);
  import bta_pkg::*;

  state_t            state, state_next;
  unit_op_t          op;
  logic [DIGIT_W-1:0] top_digit;
  logic [CNT_W-1:0]  step_cnt, step_cnt_next;
  logic [CNT_W-1:0]  dig_cnt, dig_cnt_next;
  logic              hex, hex_next;
  logic [7:0]        cap, cap_next;
  logic              out_valid, out_valid_next;
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic              out_status, out_status_next;
  logic              out_last, out_last_next;
  logic              slot_free;
  logic [7:0]        total;

  bta_dabble u_dabble (
    .clk       (clk),
    .op        (op),
    .value     (in_ch.value),
    .top_digit (top_digit)
  );

  assign slot_free = !out_valid || out_ch.ready;
  assign total     = {3'b000, dig_cnt} + (hex ? HEX_PREFIX_LEN : 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step_cnt  <= '0;
      dig_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      step_cnt  <= step_cnt_next;
      dig_cnt   <= dig_cnt_next;
    end
    hex        <= hex_next;
    cap        <= cap_next;
    out_char   <= out_char_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    op              = OP_HOLD;
    step_cnt_next   = step_cnt;
    dig_cnt_next    = dig_cnt;
    hex_next        = hex;
    cap_next        = cap;
    out_valid_next  = out_valid && !out_ch.ready;
    out_char_next   = out_char;
    out_status_next = out_status;
    out_last_next   = out_last;
    in_ch.ready     = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op            = (in_ch.kind == KIND_HEX) ? OP_LOAD_HEX : OP_LOAD_DEC;
          hex_next      = (in_ch.kind == KIND_HEX);
          cap_next      = in_ch.capacity;
          dig_cnt_next  = CNT_W'(NUM_DIGITS);
          step_cnt_next = '0;
          state_next    = (in_ch.kind == KIND_HEX) ? ST_SCAN : ST_CONV;
        end
      end
      ST_CONV: begin
        op            = OP_DABBLE;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == CNT_W'(DABBLE_STEPS - 1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // drop leading zeros, always keep at least one digit
        if (top_digit == '0 && dig_cnt != CNT_W'(1)) begin
          op           = OP_SHIFT;
          dig_cnt_next = dig_cnt - 1'b1;
        end else if (cap <= total) begin
          state_next = ST_ERR;
        end else begin
          state_next = hex ? ST_PRE0 : ST_EMIT;
        end
      end
      ST_PRE0: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_char_next   = CHAR_ZERO;
          out_status_next = STATUS_OK;
          out_last_next   = 1'b0;
          state_next      = ST_PREX;
        end
      end
      ST_PREX: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_char_next   = CHAR_X;
          out_status_next = STATUS_OK;
          out_last_next   = 1'b0;
          state_next      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          op              = OP_SHIFT;
          out_valid_next  = 1'b1;
          out_char_next   = digit_char(top_digit);
          out_status_next = STATUS_OK;
          out_last_next   = (dig_cnt == CNT_W'(1));
          dig_cnt_next    = dig_cnt - 1'b1;
          if (dig_cnt == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_char_next   = CHAR_NONE;
          out_status_next = STATUS_TOO_SMALL;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.character = out_char;
  assign out_ch.status    = out_status;
  assign out_ch.last      = out_last;

endmodule

// ----- src/bta_dabble.sv -----
// Shared digit unit: shift-add-3 binary to BCD, nibble load, digit shift-out.
module bta_dabble (
  input  logic                              clk,
  input  bta_pkg::unit_op_t                 op,
  input  logic [bta_pkg::VALUE_W-1:0]       value,
  output logic [bta_pkg::DIGIT_W-1:0]       top_digit
);
  import bta_pkg::*;

  localparam int ACC_W = BCD_W + VALUE_W;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [ACC_W-1:0]   acc_one;
  logic [ACC_W-1:0]   acc_two;

  // One shift-add-3 iteration over {bcd, bin}.
  function automatic logic [ACC_W-1:0] dabble_step(logic [ACC_W-1:0] x);
    logic [BCD_W-1:0] b;
    b = x[ACC_W-1:VALUE_W];
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
        b[DIGIT_W*i +: DIGIT_W] = b[DIGIT_W*i +: DIGIT_W] + 4'd3;
      end
    end
    return {b[BCD_W-2:0], x[VALUE_W-1:0], 1'b0};
  endfunction

  assign acc_one   = dabble_step({bcd, bin});
  assign acc_two   = dabble_step(acc_one);
  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

  always_ff @(posedge clk) begin
    case (op)
      OP_HOLD: begin
      end
      OP_LOAD_DEC: begin
        bin <= value;
        bcd <= '0;
      end
      OP_LOAD_HEX: begin
        bcd <= {{(BCD_W-VALUE_W){1'b0}}, value};
      end
      OP_DABBLE: begin
        {bcd, bin} <= acc_two;
      end
      OP_SHIFT: begin
        bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/sv/bta_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the number formatter: predicts the characters of each item and compares.
module bta_checker (
  input  logic clk,
  input  logic rst,
  bta_in_if    in_mon,
  bta_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   numbers_seen,
  output int   chars_seen,
  output int   too_small_seen
);
  import bta_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              status;
    logic              last;
  } fmt_char_t;

  fmt_char_t expected_chars[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    numbers_seen   = 0;
    chars_seen     = 0;
    too_small_seen = 0;
  end

  // Queues the characters one number should produce, or a single too-small result.
  function automatic void predict_number(logic [63:0] value, logic kind,
                                         logic [7:0] capacity);
    logic [CHAR_W-1:0] digits[$];
    logic [63:0]       rest;
    logic [3:0]        nib;
    int                total;
    fmt_char_t         item;
    rest = value;
    do begin
      if (kind == KIND_HEX) begin
        nib = rest[3:0];
        if (nib < DEC_RADIX) digits.push_front(CHAR_ZERO + {3'b000, nib});
        else digits.push_front(CHAR_ALPHA + {3'b000, nib - DEC_RADIX});
        rest = rest >> 4;
      end else begin
        digits.push_front(CHAR_ZERO + CHAR_W'(rest % 64'd10));
        rest = rest / 64'd10;
      end
    end while (rest != 0);
    total = digits.size() + ((kind == KIND_HEX) ? int'(HEX_PREFIX_LEN) : 0);
    if (int'(capacity) < total + 1) begin
      item = '{character: CHAR_NONE, status: STATUS_TOO_SMALL, last: 1'b1};
      expected_chars.push_back(item);
      return;
    end
    if (kind == KIND_HEX) begin
      item = '{character: CHAR_ZERO, status: STATUS_OK, last: 1'b0};
      expected_chars.push_back(item);
      item = '{character: CHAR_X, status: STATUS_OK, last: 1'b0};
      expected_chars.push_back(item);
    end
    foreach (digits[i]) begin
      item = '{character: digits[i], status: STATUS_OK, last: (i == digits.size() - 1)};
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    fmt_char_t want;
    if (!rst) begin
      if (in_mon.valid && in_mon.ready) begin
        predict_number(in_mon.value, in_mon.kind, in_mon.capacity);
        numbers_seen <= numbers_seen + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        chars_seen <= chars_seen + 1;
        if (out_mon.status == STATUS_TOO_SMALL) too_small_seen <= too_small_seen + 1;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result char %h status %b last %b", $time,
                   out_mon.character, out_mon.status, out_mon.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.character !== want.character || out_mon.status !== want.status ||
              out_mon.last !== want.last) begin
            $display("%0t: mismatch, expected char %h status %b last %b,",
                     $time, want.character, want.status, want.last);
            $display("    got char %h status %b last %b",
                     out_mon.character, out_mon.status, out_mon.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_chars.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, number stimulus, result back-pressure and verdict.
module tb_top;
  import bta_pkg::*;

  localparam logic KIND_DEC      = ~KIND_HEX;
  localparam int   RANDOM_ITEMS  = 450;
  localparam int   LONG_HOLD     = 400;
  localparam int   STALL_LIMIT   = 5000;
  localparam int   DRAIN_CYCLES  = 100;

  logic clk;
  logic rst;
  int   fail_count, pending, numbers_seen, chars_seen, too_small_seen;
  int   hold_req;

  bta_in_if  in_ch();
  bta_out_if out_ch();

  binary_to_ascii_number_formatter i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bta_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .numbers_seen   (numbers_seen),
    .chars_seen     (chars_seen),
    .too_small_seen (too_small_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_number(input logic [63:0] value, input logic kind,
                             input logic [7:0] capacity);
    in_ch.valid    <= 1'b1;
    in_ch.value    <= value;
    in_ch.kind     <= kind;
    in_ch.capacity <= capacity;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mix of wide random values, short values, all-ones masks, powers of ten and nibble boundaries.
  function automatic logic [63:0] random_value();
    logic [63:0] v, p;
    int          n;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        n = $urandom_range(1, 64);
        v = v >> (64 - n);
      end
      2: begin
        p = 64'd1;
        n = $urandom_range(0, 19);
        repeat (n) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      3: v = {64{1'b1}} >> $urandom_range(0, 63);
      4: v = 64'($urandom_range(0, 20));
      default: begin
        n = $urandom_range(0, 15);
        v = (64'd1 << (4 * n)) + 64'($urandom_range(0, 2)) - 64'd1;
      end
    endcase
    return v;
  endfunction

  function automatic logic [7:0] random_capacity();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 24));
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stall modes, plus one long hold-off on request.
  initial begin : result_sink
    int mode, span, hold_left, holds_done;
    mode = 0;
    span = 0;
    hold_left = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 128);
        end
        span--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 5) == 0);
          default: out_ch.ready <= ((span % 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: %0d cycles with no item moving", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int sent, burst;
    bit hold_done, drain_done;
    hold_req       = 0;
    sent           = 0;
    hold_done      = 0;
    drain_done     = 0;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.value    <= '0;
    in_ch.kind     <= KIND_DEC;
    in_ch.capacity <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, smallest and largest values, exact-fit and one-short capacities
    send_number(64'd0, KIND_DEC, 8'd2);
    send_number(64'd0, KIND_DEC, 8'd1);
    send_number(64'd0, KIND_DEC, 8'd0);
    send_number(64'd0, KIND_HEX, 8'd4);
    idle_input(2);
    send_number(64'd0, KIND_HEX, 8'd3);
    send_number(64'd1, KIND_DEC, 8'd1);
    send_number({64{1'b1}}, KIND_DEC, 8'd21);
    send_number({64{1'b1}}, KIND_DEC, 8'd20);
    send_number({64{1'b1}}, KIND_DEC, 8'd255);
    idle_input(1);
    send_number({64{1'b1}}, KIND_HEX, 8'd19);
    send_number({64{1'b1}}, KIND_HEX, 8'd18);
    send_number(64'd9, KIND_DEC, 8'd2);
    send_number(64'd10, KIND_DEC, 8'd3);
    send_number(64'd99, KIND_DEC, 8'd3);
    send_number(64'd100, KIND_DEC, 8'd3);
    send_number(64'd9999999999999999999, KIND_DEC, 8'd20);
    send_number(64'd10000000000000000000, KIND_DEC, 8'd21);
    send_number(64'hF, KIND_HEX, 8'd4);
    send_number(64'h10, KIND_HEX, 8'd5);
    send_number(64'hABCD_EF01_2345_6789, KIND_HEX, 8'd200);
    send_number(64'h8000_0000_0000_0000, KIND_HEX, 8'd19);
    send_number(64'd12345, KIND_DEC, 8'd128);
    wait_all_results();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      if (!hold_done && sent >= 150) begin
        // receiver goes quiet while items keep coming back to back
        hold_req++;
        hold_done = 1;
        burst = 30;
      end
      if (!drain_done && sent >= 300) begin
        wait_all_results();
        drain_done = 1;
      end
      repeat (burst) begin
        send_number(random_value(), 1'($urandom_range(0, 1)), random_capacity());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) idle_input(0);
      else idle_input($urandom_range(1, 12));
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d numbers in decimal and hex, %0d result items checked,",
             numbers_seen, chars_seen);
    $display("%0d of them rejected for a short buffer, with long and random output stalls.",
             too_small_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bta_pkg.sv
src/bta_if.sv
src/bta_dabble.sv
src/binary_to_ascii_number_formatter.sv
tb/sv/bta_checker.sv
tb/sv/tb_top.sv
